// ===== design/trimmed_moving_average_macros.svh =====
// Assertion macros for the trimmed moving-average filter.
`ifndef TRIMMED_MOVING_AVERAGE_MACROS_SVH
`define TRIMMED_MOVING_AVERAGE_MACROS_SVH

`ifndef ASSERT_OFF
// Checked property, held off while reset is asserted (active low).
`define TMA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("trimmed_moving_average: assertion failed");
// Checked property, live through reset as well.
`define TMA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("trimmed_moving_average: assertion failed");
`else
`define TMA_ASSERT(lbl, clk, rst_n, prop)
`define TMA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== design/tma_pkg.sv =====
// Shared types and constants of the trimmed moving-average filter.
package tma_pkg;

    localparam int unsigned SAMPLE_W       = 16;
    localparam int unsigned TRIM_MIN_COUNT = 3;   // fewest entries that get trimmed
    localparam int unsigned TRIM_DROP      = 2;   // one minimum and one maximum

    typedef logic [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        t_sample lo;
        t_sample hi;
    } t_extrema;

endpackage

// ===== design/tma_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module tma_div #(
    parameter int unsigned DVD_W = 20,
    parameter int unsigned DVS_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int unsigned STEP_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  r_q;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [STEP_W-1:0] r_steps;
    logic              r_busy;
    logic              r_done;

    logic [DVS_W:0]    w_sh;
    logic [DVS_W:0]    w_diff;
    logic              w_ge;

    // remainder stays below the divisor, so DVS_W bits hold it
    assign w_sh   = {r_rem, r_q[DVD_W-1]};
    assign w_ge   = (w_sh >= {1'b0, r_dvs});
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_steps <= STEP_W'(DVD_W);
            end else if (r_busy) begin
                r_steps <= r_steps - 1'b1;
                if (r_steps == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DVD_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_sh[DVS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ===== design/tma_scan.sv =====
// Sample window memory and sequential sum / min / max scan.
module tma_scan
    import tma_pkg::*;
#(
    parameter int unsigned WINDOW = 8,
    parameter int unsigned IDX_W  = 3,
    parameter int unsigned CNT_W  = 4,
    parameter int unsigned SUM_W  = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_sample          i_wr_data,
    input  logic             i_start,
    input  logic [CNT_W-1:0] i_count,
    output logic             o_done,
    output logic [SUM_W-1:0] o_sum,
    output t_extrema         o_ext
);

    t_sample          r_mem [WINDOW];
    t_sample          r_rd_data;
    logic [IDX_W-1:0] r_rd_idx;
    logic [CNT_W-1:0] r_count;
    logic             r_issue;
    logic             r_rd_vld;
    logic             r_rd_last;
    logic             r_done;
    logic [SUM_W-1:0] r_sum;
    t_extrema         r_ext;
    logic             w_last;

    assign w_last = (CNT_W'(r_rd_idx) == r_count - CNT_W'(1));

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (r_issue) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue   <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_rd_vld  <= r_issue;
            r_rd_last <= r_issue && w_last;
            r_done    <= r_rd_vld && r_rd_last;
            if (i_start) begin
                r_issue <= 1'b1;
            end else if (r_issue && w_last) begin
                r_issue <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_count  <= i_count;
            r_rd_idx <= '0;
            r_sum    <= '0;
            r_ext.lo <= '1;
            r_ext.hi <= '0;
        end else begin
            if (r_issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (r_rd_vld) begin
                r_sum <= r_sum + SUM_W'(r_rd_data);
                if (r_rd_data < r_ext.lo) begin
                    r_ext.lo <= r_rd_data;
                end
                if (r_rd_data > r_ext.hi) begin
                    r_ext.hi <= r_rd_data;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_sum;
    assign o_ext  = r_ext;

endmodule

// ===== design/trimmed_moving_average.sv =====
// Trimmed moving-average filter over the valid window entries (count, at most WINDOW); the sum
// is SUM_W = 16 + clog2(WINDOW+1) bits wide, 20 for WINDOW = 8. One request at a time: the next
// is taken once the result has entered the output register, later while an unread result holds
// that register. A request runs through the window scan, the serial divider, then that register.
// Synchronous active-low reset empties the window (position 0, not wrapped) and drops any result.
module trimmed_moving_average
    import tma_pkg::*;
#(
    parameter int unsigned WINDOW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [15:0]   i_sample,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [15:0]   o_filtered
);

`include "trimmed_moving_average_macros.svh"

    // widths follow from the window depth
    localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned CNT_W = $clog2(WINDOW + 1);
    localparam int unsigned SUM_W = SAMPLE_W + CNT_W;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;   // waiting for a request
    localparam logic [2:0] S_SCAN = 3'd1;   // walking the window
    localparam logic [2:0] S_DIV  = 3'd2;   // serial divide running
    localparam logic [2:0] S_FIN  = 3'd3;   // quotient ready, waiting for output slot

    logic [2:0]       r_state;
    logic [2:0]       n_state;

    // circular write position and wrap flag
    logic [IDX_W-1:0] r_pos;
    logic [IDX_W-1:0] n_pos;
    logic             r_full;
    logic             n_full;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // output register, parts the core from the downstream side
    logic             r_out_valid;
    t_sample          r_out;

    logic             w_accept;
    logic             w_wrap;
    logic             w_scan_done;
    logic [SUM_W-1:0] w_sum;
    t_extrema         w_ext;
    logic             w_trim;
    logic [SUM_W-1:0] w_dividend;
    logic [CNT_W-1:0] w_divisor;
    logic             w_div_done;
    logic [SUM_W-1:0] w_quot;
    logic             w_load_out;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    // next write position; the last slot wraps to zero and marks the window full
    assign w_wrap  = (r_pos == IDX_W'(WINDOW - 1));
    assign n_pos   = w_wrap ? '0 : r_pos + 1'b1;
    assign n_full  = r_full || w_wrap;
    assign n_count = n_full ? CNT_W'(WINDOW) : CNT_W'(n_pos);

    tma_scan #(
        .WINDOW (WINDOW),
        .IDX_W  (IDX_W),
        .CNT_W  (CNT_W),
        .SUM_W  (SUM_W)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_accept),
        .i_wr_addr (r_pos),
        .i_wr_data (i_sample),
        .i_start   (w_accept),
        .i_count   (n_count),
        .o_done    (w_scan_done),
        .o_sum     (w_sum),
        .o_ext     (w_ext)
    );

    // three or more entries: drop one min and one max, divide by count - 2;
    // fewer: plain mean. The divisor is never zero as count is at least one.
    assign w_trim     = (32'(r_count) >= TRIM_MIN_COUNT);
    assign w_dividend = w_trim ? (w_sum - SUM_W'(w_ext.lo) - SUM_W'(w_ext.hi)) : w_sum;
    assign w_divisor  = w_trim ? (r_count - CNT_W'(TRIM_DROP)) : r_count;

    tma_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_scan_done),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // result moves on once the output register is empty or being drained
    assign w_load_out = (r_state == S_FIN) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan_done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_full      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_pos   <= n_pos;
                r_full  <= n_full;
                r_count <= n_count;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // the trimmed mean lies between min and max, so the low 16 bits hold it
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= w_quot[SAMPLE_W-1:0];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_filtered = r_out;

    // ---- checks ----
    `TMA_ASSERT(a_accept_starts_scan, i_clk, i_rst_n, w_accept |=> (r_state == S_SCAN))
    `TMA_ASSERT(a_count_in_range, i_clk, i_rst_n, (r_state != S_IDLE) |-> ((r_count != '0) && (32'(r_count) <= WINDOW)))
    `TMA_ASSERT(a_div_done_in_div, i_clk, i_rst_n, w_div_done |-> (r_state == S_DIV))
    `TMA_ASSERT(a_result_bounded, i_clk, i_rst_n, (r_state == S_FIN) |-> ((w_quot <= SUM_W'(w_ext.hi)) && (w_quot >= SUM_W'(w_ext.lo))))

endmodule

// ===== tb/trimmed_moving_average_test.sv =====
// Self-checking testbench for the trimmed moving-average filter: directed table, then random samples.
module trimmed_moving_average_test;
    import tma_pkg::*;

    localparam int unsigned WINDOW      = 8;
    localparam int unsigned N_DIRECTED  = 24;
    localparam int unsigned N_RANDOM    = 700;
    localparam int unsigned RESET_LEN   = 12;
    // Slowest legal run, with long gaps and sparse ready, stays well under this watchdog limit.
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned TAIL_CYCLES = 40;     // run-on after the last expected result
    localparam int unsigned LONG_HOLD   = 400;    // receiver back-pressure stretch
    localparam int unsigned HOLD_AT     = 120;    // results seen before the long hold starts
    localparam int unsigned DRAIN_AT    = 400;    // random request before which the sender drains
    localparam int unsigned MAX_REPORTS = 10;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_SPARSE,
        STALL_PATTERN
    } t_stall_mode;

    // One directed request; want is only meaningful where known is set.
    typedef struct packed {
        t_sample sample;
        logic    known;
        t_sample want;
    } t_case;

    // Extremes first, then finish filling the window so it wraps, then two flat windows at
    // full scale and at zero. Typed-in results: the first three requests (single entry, plain
    // mean of two, trimmed mean of three) and the last request of each flat window.
    localparam t_case DIRECTED_CASES [N_DIRECTED] = '{
        '{16'hFFFF, 1'b1, 16'hFFFF},
        '{16'h0000, 1'b1, 16'h7FFF},
        '{16'h8000, 1'b1, 16'h8000},
        '{16'h0001, 1'b0, 16'h0000},
        '{16'hAAAA, 1'b0, 16'h0000},
        '{16'h5555, 1'b0, 16'h0000},
        '{16'h7FFF, 1'b0, 16'h0000},
        '{16'hFFFE, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b1, 16'hFFFF},
        '{16'h0000, 1'b0, 16'h0000},
        '{16'h0000, 1'b0, 16'h0000},
        '{16'h0000, 1'b0, 16'h0000},
        '{16'h0000, 1'b0, 16'h0000},
        '{16'h0000, 1'b0, 16'h0000},
        '{16'h0000, 1'b0, 16'h0000},
        '{16'h0000, 1'b0, 16'h0000},
        '{16'h0000, 1'b1, 16'h0000}
    };

    logic    i_clk;
    logic    i_rst_n;
    logic    i_valid;
    logic    o_ready;
    t_sample i_sample;
    logic    o_valid;
    logic    i_ready;
    t_sample o_filtered;

    trimmed_moving_average #(
        .WINDOW(WINDOW)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_sample  (i_sample),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_filtered(o_filtered)
    );

    // Our own copy of the window, used to work out each expected result.
    t_sample                     win_copy [WINDOW];
    logic [$clog2(WINDOW)-1:0]   wr_ptr  = '0;
    logic                        wrapped = 1'b0;
    t_sample                     last_sample = '0;

    t_sample     filtered_due [$];    // expected results, oldest first
    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;
    int unsigned cycles       = 0;

    // Receiver stall state.
    t_stall_mode stall_mode    = STALL_NONE;
    int unsigned mode_left     = 0;
    int unsigned hold_left     = 0;
    logic        hold_done     = 1'b0;
    logic [15:0] stall_pattern = 16'hFFFF;
    logic [3:0]  pattern_phase = '0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Store the sample, advance the write pointer, then trim and average the valid entries.
    function automatic t_sample predict_filtered(input t_sample s);
        int unsigned count;
        int unsigned k;
        logic [31:0] sum;
        t_sample     lo;
        t_sample     hi;
        win_copy[wr_ptr] = s;
        if (wr_ptr == WINDOW - 1) begin
            wr_ptr  = '0;
            wrapped = 1'b1;
        end else begin
            wr_ptr = wr_ptr + 1'b1;
        end
        count = wrapped ? WINDOW : wr_ptr;
        sum   = '0;
        lo    = '1;
        hi    = '0;
        for (k = 0; k < count; k++) begin
            if (win_copy[k] < lo) lo = win_copy[k];
            if (win_copy[k] > hi) hi = win_copy[k];
            sum = sum + win_copy[k];
        end
        // count is never zero once a sample is in
        if (count >= TRIM_MIN_COUNT)
            return t_sample'((sum - lo - hi) / (count - TRIM_DROP));
        return t_sample'(sum / count);
    endfunction

    // Mix of full-range values, values near the rails, repeats of the last one and single-bit flips of it.
    function automatic t_sample random_sample();
        case ($urandom_range(0, 7))
            0: return t_sample'($urandom_range(0, 255));
            1: return t_sample'($urandom_range(16'hFF00, 16'hFFFF));
            2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            3: return last_sample ^ t_sample'(1 << $urandom_range(0, 15));
            4: return last_sample;
            default: return t_sample'($urandom());
        endcase
    endfunction

    // Present one request and hold it until taken; valid is left high for back-to-back requests.
    task automatic offer(input t_sample s, input logic known, input t_sample want);
        t_sample predicted;
        i_valid  <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predicted = predict_filtered(s);
        filtered_due.push_back(known ? want : predicted);
        last_sample = s;
    endtask

    task automatic idle(input int unsigned n);
        if (n != 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Always spends at least one edge, so a following offer never re-drives valid in this step.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (filtered_due.size() != 0);
    endtask

    task automatic note_mismatch(input string what, input t_sample want, input t_sample got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch (%s): expected %h, got %h, cycle %0d", what, want, got, cycles);
    endtask

    // Sender.
    initial begin
        int unsigned burst_left;
        int unsigned gap;
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_sample <= '0;
        foreach (win_copy[k]) win_copy[k] = '0;
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, with the odd short gap.
        foreach (DIRECTED_CASES[n]) begin
            if ($urandom_range(0, 3) == 0)
                idle($urandom_range(1, 5));
            offer(DIRECTED_CASES[n].sample, DIRECTED_CASES[n].known, DIRECTED_CASES[n].want);
        end
        wait_drained();

        // Random requests in bursts; the idle gaps between bursts land on every phase of the scan
        // and of the divide, and some bursts run back to back.
        burst_left = 0;
        for (int unsigned n = 0; n < N_RANDOM; n++) begin
            if (burst_left == 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: gap = $urandom_range(1, 3);
                    5, 6, 7, 8:    gap = $urandom_range(4, 40);
                    default:       gap = 0;
                endcase
                idle(gap);
                burst_left = $urandom_range(1, 24);
            end
            // once mid-run, let every outstanding result come home
            if (n == DRAIN_AT)
                wait_drained();
            offer(random_sample(), 1'b0, '0);
            burst_left--;
        end
        i_valid <= 1'b0;

        while (filtered_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && filtered_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Receiver: checks each accepted result, then picks ready for the next edge.
    always @(posedge i_clk) begin
        t_sample want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (filtered_due.size() == 0) begin
                    note_mismatch("nothing pending", '0, o_filtered);
                end else begin
                    want = filtered_due.pop_front();
                    if (o_filtered !== want)
                        note_mismatch("filtered", want, o_filtered);
                end
                results_seen++;
            end

            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (!hold_done && results_seen == HOLD_AT) begin
                // long back-pressure: the sender keeps offering, so the block fills and stalls
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                i_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode    = t_stall_mode'($urandom_range(0, 3));
                    mode_left     = $urandom_range(50, 150);
                    stall_pattern = 16'($urandom());
                end else begin
                    mode_left--;
                end
                pattern_phase = pattern_phase + 1'b1;
                case (stall_mode)
                    STALL_NONE:    i_ready <= 1'b1;
                    STALL_RANDOM:  i_ready <= 1'($urandom_range(0, 1));
                    STALL_SPARSE:  i_ready <= ($urandom_range(0, 3) == 0);
                    STALL_PATTERN: i_ready <= stall_pattern[pattern_phase];
                    default:       i_ready <= 1'b1;
                endcase
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

// ===== trimmed_moving_average.f =====
+incdir+design
design/tma_pkg.sv
design/tma_div.sv
design/tma_scan.sv
design/trimmed_moving_average.sv
tb/trimmed_moving_average_test.sv
